/* rtl/core/assert_macros.svh */
// Assertion macros shared by the client liveness table RTL.
// Depends on nothing; each macro compiles away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CHK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: check failed");
`define ASSERT_CHK_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);
`else
`define ASSERT_CHK(name, clk, rst_n, prop)
`define ASSERT_CHK_MSG(name, clk, rst_n, prop, msg)
`endif

`endif

/* rtl/core/clt_pkg.sv */
// Package for the client liveness table: sizes, codes, beat payload types
// and the command/status bundles between controller and datapath. No dependencies.
package clt_pkg;

  localparam int unsigned CAPACITY  = 10;
  localparam int unsigned CntW      = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ReqW      = 2;
  localparam int unsigned IdW       = 23;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CountOutW = 4;

  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd35;

  typedef enum logic [ReqW-1:0] {
    REQ_REGISTER = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_SWEEP    = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EVICTED   = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  // Which result the datapath builds when the controller asks for a beat.
  typedef enum logic [1:0] {
    EMIT_REG  = 2'd0,
    EMIT_RMV  = 2'd1,
    EMIT_PEND = 2'd2,
    EMIT_END  = 2'd3
  } emit_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [IdW-1:0]   client_id;
    logic [TimeW-1:0] now_time;
  } clt_in_t;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [IdW-1:0]       result_id;
    logic [CountOutW-1:0] entry_count;
    logic                 last;
  } clt_out_t;

  typedef struct packed {
    logic  load;
    logic  drop;
    logic  load_gone;
    logic  inc_idx;
    logic  set_pend;
    logic  emit;
    emit_e emit_sel;
  } clt_cmd_t;

  typedef struct packed {
    logic match_any;
    logic scan_end;
    logic stale;
    logic pend_valid;
    logic out_free;
  } clt_sts_t;

endpackage

/* rtl/core/client_liveness_table.sv */
// Steps: a register request is loaded, then its beat goes to the output register; a
// remove drops every matching entry one by one, then sends its beat; a sweep walks the
// table, removing each stale entry and holding its eviction beat back one step.
// Throughput: one item at a time; the walk takes one step per cycle when not stalled.
// Output register: the next item is accepted while a finished beat waits on the stall.
// Reset: table empty, timeout 35 seconds, no clearing pass; entry storage is not reset.
module client_liveness_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  clt_pkg::clt_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output clt_pkg::clt_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [clt_pkg::TimeoutW-1:0] cfg_wdata_i
);
  import clt_pkg::*;

  clt_cmd_t cmd;
  clt_sts_t sts;

  clt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_data_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  clt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/clt_datapath.sv */
// Datapath of the client liveness table: entry registers, compaction shifter,
// age check, pending eviction holder and output register. Uses clt_pkg.
`include "assert_macros.svh"

module clt_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  clt_pkg::clt_in_t          in_data_i,
  input  clt_pkg::clt_cmd_t         cmd_i,
  output clt_pkg::clt_sts_t         sts_o,
  input  logic                      cfg_we_i,
  input  logic [clt_pkg::TimeoutW-1:0] cfg_wdata_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output clt_pkg::clt_out_t         out_data_o
);
  import clt_pkg::*;

  logic [IdW-1:0]      ids_q   [CAPACITY];
  logic [TimeW-1:0]    times_q [CAPACITY];
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [IdW-1:0]      key_q;
  logic [TimeW-1:0]    now_q;
  logic [TimeoutW-1:0] timeout_q;
  logic                hit_q, hit_d;
  logic                pend_valid_q, pend_valid_d;
  logic [IdW-1:0]      pend_id_q;
  logic [CntW-1:0]     pend_cnt_q;
  logic                out_valid_q, out_valid_d;
  clt_out_t            out_q, out_d;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] shift;
  logic                full;
  logic                append;
  logic [IdW-1:0]      rd_id;
  logic [TimeW-1:0]    rd_time;
  logic [TimeW-1:0]    age;

  // Entries at or above the first live match move down one slot on a drop step.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int j = 0; j < CAPACITY; j++) begin
      match[j] = (CntW'(j) < count_q) && (ids_q[j] == key_q);
      seen     = seen | match[j];
      shift[j] = seen;
    end
  end

  assign full    = (count_q >= CntW'(CAPACITY));
  assign append  = cmd_i.emit && (cmd_i.emit_sel == EMIT_REG) && !full;
  assign rd_id   = ids_q[idx_q[AddrW-1:0]];
  assign rd_time = times_q[idx_q[AddrW-1:0]];
  assign age     = now_q - rd_time;

  assign sts_o.match_any  = |match;
  assign sts_o.scan_end   = (idx_q >= count_q);
  assign sts_o.stale      = (age > TimeW'(timeout_q));
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.drop) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (shift[j]) begin
          ids_q[j]   <= ids_q[j+1];
          times_q[j] <= times_q[j+1];
        end
      end
    end else if (append) begin
      ids_q[count_q[AddrW-1:0]]   <= key_q;
      times_q[count_q[AddrW-1:0]] <= now_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.drop) begin
      count_d = count_q - CntW'(1);
    end else if (append) begin
      count_d = count_q + CntW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_q + CntW'(1);
    end
    hit_d = hit_q;
    if (cmd_i.load) begin
      hit_d = 1'b0;
    end else if (cmd_i.drop) begin
      hit_d = 1'b1;
    end
    pend_valid_d = pend_valid_q;
    if (cmd_i.load) begin
      pend_valid_d = 1'b0;
    end else if (cmd_i.set_pend) begin
      pend_valid_d = 1'b1;
    end else if (cmd_i.emit && (cmd_i.emit_sel == EMIT_PEND)) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      unique case (cmd_i.emit_sel)
        EMIT_REG: begin
          if (full) begin
            out_d = '{status: ST_FULL, result_id: '0,
                      entry_count: CountOutW'(count_q), last: 1'b1};
          end else begin
            out_d = '{status: ST_ADDED, result_id: key_q,
                      entry_count: CountOutW'(count_q + CntW'(1)), last: 1'b1};
          end
        end
        EMIT_RMV: begin
          if (hit_q) begin
            out_d = '{status: ST_REMOVED, result_id: key_q,
                      entry_count: CountOutW'(count_q), last: 1'b1};
          end else begin
            out_d = '{status: ST_NOT_FOUND, result_id: '0,
                      entry_count: CountOutW'(count_q), last: 1'b1};
          end
        end
        EMIT_PEND: begin
          out_d = '{status: ST_EVICTED, result_id: pend_id_q,
                    entry_count: CountOutW'(pend_cnt_q), last: 1'b0};
        end
        EMIT_END: begin
          if (pend_valid_q) begin
            out_d = '{status: ST_EVICTED, result_id: pend_id_q,
                      entry_count: CountOutW'(pend_cnt_q), last: 1'b1};
          end else begin
            out_d = '{status: ST_NONE, result_id: '0,
                      entry_count: CountOutW'(count_q), last: 1'b1};
          end
        end
        default: begin
          out_d = out_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      timeout_q    <= TIMEOUT_RESET;
    end else begin
      count_q      <= count_d;
      idx_q        <= idx_d;
      hit_q        <= hit_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load) begin
      key_q <= in_data_i.client_id;
      now_q <= in_data_i.now_time;
    end else if (cmd_i.load_gone) begin
      key_q <= rd_id;
    end
    if (cmd_i.set_pend) begin
      pend_id_q  <= key_q;
      pend_cnt_q <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_CHK(a_count_in_range, clk_i, rst_ni, count_q <= CntW'(CAPACITY))
  `ASSERT_CHK(a_drop_shrinks, clk_i, rst_ni, cmd_i.drop |=> count_q == $past(count_q) - CntW'(1))
  `ASSERT_CHK(a_pend_emit_has_pend, clk_i, rst_ni, (cmd_i.emit && cmd_i.emit_sel == EMIT_PEND) |-> pend_valid_q)

endmodule

/* rtl/core/clt_ctrl.sv */
// Controller of the client liveness table: sequences register, remove and
// sweep requests over the datapath through clt_pkg command and status bundles.
`include "assert_macros.svh"

module clt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [clt_pkg::ReqW-1:0] req_i,
  input  clt_pkg::clt_sts_t sts_i,
  output clt_pkg::clt_cmd_t cmd_o
);
  import clt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REG  = 4'b0010,
    S_DROP = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [ReqW-1:0] req_q, req_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          req_d      = req_i;
          if (req_i == REQ_REGISTER) begin
            state_d = S_REG;
          end else if (req_i == REQ_REMOVE) begin
            state_d = S_DROP;
          end else if (req_i == REQ_SWEEP) begin
            state_d = S_SCAN;
          end
        end
      end
      S_REG: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_REG;
          state_d        = S_IDLE;
        end
      end
      // One matching entry leaves per cycle until none is left.
      S_DROP: begin
        if (sts_i.match_any) begin
          cmd_o.drop = 1'b1;
        end else if (req_q == REQ_REMOVE) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_RMV;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.set_pend = 1'b1;
          state_d        = S_SCAN;
        end
      end
      // An eviction is held back one step, so its last flag is known when sent.
      S_SCAN: begin
        if (sts_i.scan_end) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_END;
            state_d        = S_IDLE;
          end
        end else if (sts_i.stale) begin
          if (sts_i.pend_valid) begin
            if (sts_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = EMIT_PEND;
            end
          end else begin
            cmd_o.load_gone = 1'b1;
            state_d         = S_DROP;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
    end
  end

  `ASSERT_CHK(a_emit_when_free, clk_i, rst_ni, cmd_o.emit |-> sts_i.out_free)
  `ASSERT_CHK(a_drop_needs_match, clk_i, rst_ni, cmd_o.drop |-> sts_i.match_any)
  `ASSERT_CHK(a_accept_leaves_idle, clk_i, rst_ni, (state_q == S_IDLE && in_valid_i && (req_i == REQ_REGISTER || req_i == REQ_REMOVE || req_i == REQ_SWEEP)) |=> state_q != S_IDLE)

endmodule
